[hw/rtl/sbcp_pkg.sv]
// shared types, constants and helpers for the sector block cache with prefetch queue
package sbcp_pkg;

  // sizes; block size and ring depth are powers of two
  localparam int SECTORS_PER_BLOCK = 16;
  localparam int INDEX_BITS        = 6;
  localparam int ENTRIES           = 1 << INDEX_BITS;
  localparam int PREFETCH_DEPTH    = 4;
  localparam int RING_DEPTH        = 16;

  localparam int LBA_W      = 20;
  localparam int CAND_W     = LBA_W + 2;
  localparam int BLK_SHIFT  = $clog2(SECTORS_PER_BLOCK);
  localparam int RING_PTR_W = $clog2(RING_DEPTH);
  localparam int RING_CNT_W = $clog2(RING_DEPTH + 1);
  localparam int RA_CNT_W   = $clog2(PREFETCH_DEPTH + 1);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LBA_W;
  localparam int QLEVEL_W   = 5;
  localparam int NCOUNT_W   = 3;

  typedef enum logic [2:0] {
    CMD_LOOKUP     = 3'd0,
    CMD_FILL       = 3'd1,
    CMD_READ_AHEAD = 3'd2,
    CMD_POP        = 3'd3,
    CMD_FAIL       = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_HALT  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISC_SECTORS    = 1'd0,
    REG_PREFETCH_ENABLE = 1'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_LK_RES,
    S_RA_CHECK,
    S_RA_TAG,
    S_RA_SCAN,
    S_RA_PUT,
    S_RA_NEXT,
    S_POP_RES,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [2:0]       command;
    logic [LBA_W-1:0] lba;
    logic [LBA_W-1:0] track_start;
    logic [LBA_W-1:0] track_end;
    logic             track_known;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic                hit;
    logic [LBA_W-1:0]    block_addr;
    logic                pop_valid;
    logic [NCOUNT_W-1:0] queued_count;
    logic [NCOUNT_W-1:0] dropped_count;
    logic [QLEVEL_W-1:0] queue_level;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic    cap;
    logic    set_status;
    status_t status_val;
    logic    lk_hit;
    logic    fill;
    logic    fail;
    logic    pop;
    logic    ra_next;
    logic    scan_inc;
    logic    put;
    logic    drop;
    logic    emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] command;
    logic       halted;
    logic       out_range;
    logic       track_known;
    logic       enable;
    logic       ring_empty;
    logic       ring_full;
    logic       ra_stop;
    logic       cached;
    logic       scan_match;
    logic       scan_last;
    logic       out_busy;
  } dp_status_t;

  // folded block number selects the directory entry
  function automatic logic [INDEX_BITS-1:0] slot_of(input logic [LBA_W-1:0] blk);
    logic [LBA_W-1:0] b;
    b = blk >> BLK_SHIFT;
    return INDEX_BITS'(b ^ (b >> INDEX_BITS));
  endfunction

endpackage

[hw/rtl/sector_block_cache_prefetch_top.sv]
// top level of the sector block cache directory with read-ahead request queue
// lookup and a pop that returns a request pass through a result state before emit, all
// else goes from dispatch straight to emit; read_ahead on a known track walks its blocks:
// with prefetch on, each gets a tag check and a one-entry-per-cycle duplicate ring scan
// one transaction at a time; the next accept comes once the result register is loaded
// reset clears valid bits, ring pointers, halt flag and config at once; no clearing pass
module sector_block_cache_prefetch_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sbcp_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output sbcp_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [sbcp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbcp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sbcp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  sbcp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  sbcp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[hw/rtl/sbcp_ctrl.sv]
// command sequencer: walks each transaction through the datapath steps
module sbcp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sbcp_pkg::dp_status_t st,
  output sbcp_pkg::dp_cmd_t    cmd
);
  import sbcp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd.cap        = 1'b0;
    cmd.set_status = 1'b0;
    cmd.status_val = ST_OK;
    cmd.lk_hit     = 1'b0;
    cmd.fill       = 1'b0;
    cmd.fail       = 1'b0;
    cmd.pop        = 1'b0;
    cmd.ra_next    = 1'b0;
    cmd.scan_inc   = 1'b0;
    cmd.put        = 1'b0;
    cmd.drop       = 1'b0;
    cmd.emit       = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap    = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_EMIT;
        case (st.command)
          CMD_LOOKUP: begin
            if (st.halted) begin
              cmd.set_status = 1'b1;
              cmd.status_val = ST_HALT;
            end else if (st.out_range) begin
              cmd.set_status = 1'b1;
              cmd.status_val = ST_RANGE;
            end else begin
              state_next = S_LK_RES;
            end
          end
          CMD_FILL: begin
            if (st.halted) begin
              cmd.set_status = 1'b1;
              cmd.status_val = ST_HALT;
            end else if (st.out_range) begin
              cmd.set_status = 1'b1;
              cmd.status_val = ST_RANGE;
            end else begin
              cmd.fill = 1'b1;
            end
          end
          CMD_READ_AHEAD: begin
            if (st.halted) begin
              cmd.set_status = 1'b1;
              cmd.status_val = ST_HALT;
            end else if (st.track_known) begin
              state_next = S_RA_CHECK;
            end
          end
          CMD_POP: begin
            if (st.halted) begin
              cmd.set_status = 1'b1;
              cmd.status_val = ST_HALT;
            end else if (st.enable && !st.ring_empty) begin
              state_next = S_POP_RES;
            end
          end
          CMD_FAIL: begin
            cmd.fail       = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status_val = ST_HALT;
          end
          default: begin
            state_next = S_EMIT;
          end
        endcase
      end
      S_LK_RES: begin
        cmd.lk_hit = 1'b1;
        state_next = S_EMIT;
      end
      S_RA_CHECK: begin
        if (st.ra_stop) begin
          state_next = S_EMIT;
        end else if (!st.enable) begin
          state_next = S_RA_NEXT;
        end else begin
          state_next = S_RA_TAG;
        end
      end
      S_RA_TAG: begin
        if (st.cached) begin
          state_next = S_RA_NEXT;
        end else if (st.ring_empty) begin
          state_next = S_RA_PUT;
        end else begin
          // first ring entry is being read now
          cmd.scan_inc = 1'b1;
          state_next   = S_RA_SCAN;
        end
      end
      S_RA_SCAN: begin
        if (st.scan_match) begin
          state_next = S_RA_NEXT;
        end else if (st.scan_last) begin
          state_next = S_RA_PUT;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_RA_PUT: begin
        if (st.ring_full) begin
          cmd.drop = 1'b1;
        end else begin
          cmd.put = 1'b1;
        end
        state_next = S_RA_NEXT;
      end
      S_RA_NEXT: begin
        cmd.ra_next = 1'b1;
        state_next  = S_RA_CHECK;
      end
      S_POP_RES: begin
        cmd.pop    = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!st.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/sbcp_dp.sv]
// datapath: config registers, tag directory, request ring and result register
module sbcp_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  sbcp_pkg::in_item_t                  in_data,
  input  logic                                cfg_we,
  input  logic [sbcp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sbcp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  sbcp_pkg::dp_cmd_t                   cmd,
  output sbcp_pkg::dp_status_t                st,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sbcp_pkg::out_item_t                 out_data
);
  import sbcp_pkg::*;

  logic [LBA_W-1:0]      disc_sectors;
  logic                  prefetch_enable;
  in_item_t              item;

  logic [ENTRIES-1:0]    entry_valid;
  logic [LBA_W-1:0]      tag_mem [ENTRIES];
  logic [LBA_W-1:0]      tag_q;
  logic                  vld_q;

  logic [LBA_W-1:0]      ring_mem [RING_DEPTH];
  logic [LBA_W-1:0]      ring_q;
  logic [RING_PTR_W-1:0] head;
  logic [RING_PTR_W-1:0] tail;
  logic [RING_CNT_W-1:0] count;
  logic                  halted;

  logic [CAND_W-1:0]     cand;
  logic [RA_CNT_W-1:0]   ra_i;
  logic [RING_CNT_W-1:0] scan;

  status_t               w_status;
  logic                  w_hit;
  logic [LBA_W-1:0]      w_addr;
  logic                  w_popv;
  logic [RA_CNT_W-1:0]   w_nq;
  logic [RA_CNT_W-1:0]   w_nd;

  logic [CAND_W-1:0]     in_blk;
  logic [INDEX_BITS-1:0] slot;
  logic [RING_PTR_W-1:0] ring_raddr;

  assign in_blk     = CAND_W'((in_data.lba >> BLK_SHIFT) << BLK_SHIFT);
  assign slot       = slot_of(cand[LBA_W-1:0]);
  assign ring_raddr = head + scan[RING_PTR_W-1:0];

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      disc_sectors    <= '0;
      prefetch_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DISC_SECTORS:    disc_sectors    <= cfg_data[LBA_W-1:0];
        REG_PREFETCH_ENABLE: prefetch_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // tag directory: valid bits in flops, tags in a memory with registered read
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.fill) begin
      entry_valid[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      tag_mem[slot] <= cand[LBA_W-1:0];
    end
    tag_q <= tag_mem[slot];
    vld_q <= entry_valid[slot];
  end

  // request ring storage
  always_ff @(posedge clk) begin
    if (cmd.put) begin
      ring_mem[tail] <= cand[LBA_W-1:0];
    end
    ring_q <= ring_mem[ring_raddr];
  end

  // ring pointers and halt flag
  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      tail   <= '0;
      count  <= '0;
      halted <= 1'b0;
    end else if (cmd.fail) begin
      head   <= '0;
      tail   <= '0;
      count  <= '0;
      halted <= 1'b1;
    end else if (cmd.put) begin
      tail  <= tail + 1'b1;
      count <= count + 1'b1;
    end else if (cmd.pop) begin
      head  <= head + 1'b1;
      count <= count - 1'b1;
    end
  end

  // captured transaction, walk counters and working result
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      item     <= in_data;
      ra_i     <= '0;
      scan     <= '0;
      w_status <= ST_OK;
      w_hit    <= 1'b0;
      w_popv   <= 1'b0;
      w_nq     <= '0;
      w_nd     <= '0;
      // read-ahead starts one block later when the block begins before the track
      if (in_data.command == CMD_READ_AHEAD &&
          in_blk < CAND_W'(in_data.track_start)) begin
        cand <= in_blk + CAND_W'(SECTORS_PER_BLOCK);
      end else begin
        cand <= in_blk;
      end
      if (in_data.command == CMD_LOOKUP || in_data.command == CMD_FILL) begin
        w_addr <= in_blk[LBA_W-1:0];
      end else begin
        w_addr <= '0;
      end
    end else begin
      if (cmd.set_status) begin
        w_status <= cmd.status_val;
      end
      if (cmd.lk_hit) begin
        w_hit <= st.cached;
      end
      if (cmd.pop) begin
        w_addr <= ring_q;
        w_popv <= 1'b1;
      end
      if (cmd.put) begin
        w_nq <= w_nq + 1'b1;
      end
      if (cmd.drop) begin
        w_nd <= w_nd + 1'b1;
      end
      if (cmd.ra_next) begin
        cand <= cand + CAND_W'(SECTORS_PER_BLOCK);
        ra_i <= ra_i + 1'b1;
        scan <= '0;
      end else if (cmd.scan_inc) begin
        scan <= scan + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.status        <= w_status;
      out_data.hit           <= w_hit;
      out_data.block_addr    <= w_addr;
      out_data.pop_valid     <= w_popv;
      out_data.queued_count  <= NCOUNT_W'(w_nq);
      out_data.dropped_count <= NCOUNT_W'(w_nd);
      out_data.queue_level   <= QLEVEL_W'(count);
    end
  end

  always_comb begin
    st.command     = item.command;
    st.halted      = halted;
    st.out_range   = item.lba >= disc_sectors;
    st.track_known = item.track_known;
    st.enable      = prefetch_enable;
    st.ring_empty  = count == '0;
    st.ring_full   = count == RING_CNT_W'(RING_DEPTH);
    st.ra_stop     = (ra_i == RA_CNT_W'(PREFETCH_DEPTH)) ||
                     (cand >= CAND_W'(disc_sectors)) ||
                     (cand < CAND_W'(item.track_start)) ||
                     (cand + CAND_W'(SECTORS_PER_BLOCK - 1) > CAND_W'(item.track_end));
    st.cached      = vld_q && (tag_q == cand[LBA_W-1:0]);
    // ring_q holds the entry one behind the scan counter
    st.scan_match  = ring_q == cand[LBA_W-1:0];
    st.scan_last   = scan == count;
    st.out_busy    = out_valid && !out_ready;
  end

endmodule

[hw/rtl/sbcp_checker.sv]
// port-level checker for the sector block cache top, with its bind
module sbcp_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input sbcp_pkg::out_item_t out_data
);
  import sbcp_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one transaction in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while busy");

  // a halted block has an empty ring and returns nothing
  a_halt_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_HALT |->
      out_data.queue_level == '0 && !out_data.pop_valid && !out_data.hit)
    else $error("halted result with pending requests or data");

  // a successful pop is an ok result with no read-ahead counts
  a_pop_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.pop_valid |->
      out_data.status == ST_OK && out_data.queued_count == '0 &&
      out_data.dropped_count == '0)
    else $error("pop result carries bad fields");

  // read-ahead never tries more blocks than its depth and the ring never overflows
  a_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      4'(out_data.queued_count) + 4'(out_data.dropped_count) <= 4'(PREFETCH_DEPTH) &&
      6'(out_data.queue_level) <= 6'(RING_DEPTH))
    else $error("result counts out of range");

endmodule

bind sector_block_cache_prefetch_top sbcp_checker u_sbcp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[tb/testbench.sv]
// self-checking testbench for the sector block cache directory and read-ahead queue
module testbench;
  import sbcp_pkg::*;

  typedef enum {BLK_SKIPPED, BLK_QUEUED, BLK_DROPPED} ra_outcome_t;

  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
  localparam int unsigned LBA_MAX        = (1 << LBA_W) - 1;
  localparam int QUIET_LIMIT             = 2000;
  localparam int PHASES                  = 8;
  localparam int PHASE_ITEMS             = 100;

  class cache_reply_scoreboard;
    bit               ent_valid [ENTRIES];
    logic [LBA_W-1:0] ent_tag [ENTRIES];
    int unsigned      ring [RING_DEPTH];
    int unsigned      head, tail, level;
    bit               halted;
    int unsigned      disc_sectors;
    bit               pf_enable;
    out_item_t        pending_replies [$];
    int               errors;

    function new();
      foreach (ent_valid[i]) begin
        ent_valid[i] = 1'b0;
        ent_tag[i]   = '0;
      end
      head = 0;
      tail = 0;
      level = 0;
      halted = 1'b0;
      disc_sectors = 0;
      pf_enable = 1'b0;
      errors = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_DISC_SECTORS) disc_sectors = val;
      else pf_enable = val[0];
    endfunction

    function int unsigned slot_for(int unsigned blk);
      int unsigned b;
      b = blk / SECTORS_PER_BLOCK;
      b = b ^ (b >> INDEX_BITS);
      return b % ENTRIES;
    endfunction

    function bit block_cached(int unsigned blk);
      int unsigned s;
      s = slot_for(blk);
      return ent_valid[s] && (ent_tag[s] == blk);
    endfunction

    function ra_outcome_t queue_block(int unsigned blk);
      int unsigned k;
      if (!pf_enable || blk >= disc_sectors || block_cached(blk)) return BLK_SKIPPED;
      for (k = 0; k < level; k++) begin
        if (ring[(head + k) % RING_DEPTH] == blk) return BLK_SKIPPED;
      end
      if (level >= RING_DEPTH) return BLK_DROPPED;
      ring[tail] = blk;
      tail = (tail + 1) % RING_DEPTH;
      level++;
      return BLK_QUEUED;
    endfunction

    function out_item_t predict_reply(in_item_t it);
      out_item_t   r;
      int unsigned lba, blk, nb, ts, te, nq, nd, k;
      ra_outcome_t res;
      r   = '0;
      lba = it.lba;
      ts  = it.track_start;
      te  = it.track_end;
      blk = (lba / SECTORS_PER_BLOCK) * SECTORS_PER_BLOCK;
      nq  = 0;
      nd  = 0;
      case (it.command)
        CMD_LOOKUP: begin
          r.block_addr = LBA_W'(blk);
          if (halted) r.status = ST_HALT;
          else if (lba >= disc_sectors) r.status = ST_RANGE;
          else r.hit = block_cached(blk);
        end
        CMD_FILL: begin
          r.block_addr = LBA_W'(blk);
          if (halted) r.status = ST_HALT;
          else if (lba >= disc_sectors) r.status = ST_RANGE;
          else begin
            ent_tag[slot_for(blk)]   = LBA_W'(blk);
            ent_valid[slot_for(blk)] = 1'b1;
          end
        end
        CMD_READ_AHEAD: begin
          if (halted) r.status = ST_HALT;
          else if (it.track_known) begin
            // address before the track start rounds up to the next block
            if (blk < ts) blk += SECTORS_PER_BLOCK;
            for (k = 0; k < PREFETCH_DEPTH; k++) begin
              nb = blk + k * SECTORS_PER_BLOCK;
              if (nb >= disc_sectors || nb < ts || nb + SECTORS_PER_BLOCK - 1 > te) break;
              res = queue_block(nb);
              if (res == BLK_QUEUED) nq++;
              else if (res == BLK_DROPPED) nd++;
            end
          end
        end
        CMD_POP: begin
          if (halted) r.status = ST_HALT;
          else if (pf_enable && level != 0) begin
            r.block_addr = LBA_W'(ring[head]);
            head = (head + 1) % RING_DEPTH;
            level--;
            r.pop_valid = 1'b1;
          end
        end
        CMD_FAIL: begin
          halted = 1'b1;
          head = 0;
          tail = 0;
          level = 0;
          r.status = ST_HALT;
        end
        default: ;
      endcase
      r.queued_count  = NCOUNT_W'(nq);
      r.dropped_count = NCOUNT_W'(nd);
      r.queue_level   = QLEVEL_W'(level);
      return r;
    endfunction

    function void note_input(in_item_t it);
      pending_replies = {pending_replies, predict_reply(it)};
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_field(string name, logic [LBA_W-1:0] got, logic [LBA_W-1:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_replies.size() == 0) begin
        report("result with no transaction waiting");
        return;
      end
      want = pending_replies.pop_front();
      check_field("status", LBA_W'(got.status), LBA_W'(want.status));
      check_field("hit", LBA_W'(got.hit), LBA_W'(want.hit));
      check_field("block_addr", got.block_addr, want.block_addr);
      check_field("pop_valid", LBA_W'(got.pop_valid), LBA_W'(want.pop_valid));
      check_field("queued_count", LBA_W'(got.queued_count), LBA_W'(want.queued_count));
      check_field("dropped_count", LBA_W'(got.dropped_count), LBA_W'(want.dropped_count));
      check_field("queue_level", LBA_W'(got.queue_level), LBA_W'(want.queue_level));
    endtask

    task flush_check();
      if (pending_replies.size() != 0)
        report($sformatf("%0d expected results never arrived", pending_replies.size()));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cache_reply_scoreboard sb;
  bit                    idle_on = 1'b0;
  int unsigned           disc_cur;
  int unsigned           region_base;

  sector_block_cache_prefetch_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // ends the run when no transaction moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic in_item_t mk_item(logic [2:0] cmd, int unsigned lba, int unsigned ts,
                                       int unsigned te, bit known);
    in_item_t it;
    it.command     = cmd;
    it.lba         = LBA_W'(lba);
    it.track_start = LBA_W'(ts);
    it.track_end   = LBA_W'(te);
    it.track_known = known;
    return it;
  endfunction

  function automatic in_item_t random_item();
    int unsigned pick, lba, ts, te;
    logic [2:0]  cmd;
    pick = $urandom_range(0, 99);
    if (pick < 30) cmd = CMD_LOOKUP;
    else if (pick < 52) cmd = CMD_FILL;
    else if (pick < 77) cmd = CMD_READ_AHEAD;
    else if (pick < 95) cmd = CMD_POP;
    else cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    // mostly a small working region so fills turn into hits and queue overlaps
    pick = $urandom_range(0, 9);
    if (pick < 7) lba = (region_base + $urandom_range(0, 1023)) & LBA_MAX;
    else if (pick == 7) lba = $urandom_range(0, LBA_MAX);
    else lba = (disc_cur - $urandom_range(0, 64)) & LBA_MAX;
    if ($urandom_range(0, 9) < 8) begin
      ts = $urandom_range(0, 64);
      ts = (lba > ts) ? lba - ts : 0;
      te = lba + $urandom_range(0, 160);
      if (te > LBA_MAX) te = LBA_MAX;
    end else begin
      ts = $urandom_range(0, LBA_MAX);
      te = $urandom_range(0, LBA_MAX);
    end
    return mk_item(cmd, lba, ts, te, $urandom_range(0, 99) < 88);
  endfunction

  task send_item(input in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task wait_all_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.set_register(idx, val);
  endtask

  task configure(int unsigned disc, bit enable);
    write_reg(REG_DISC_SECTORS, CFG_DATA_W'(disc));
    write_reg(REG_PREFETCH_ENABLE, CFG_DATA_W'(enable));
    disc_cur = disc;
  endtask

  initial begin
    int unsigned disc;
    bit          enable;
    sb        = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_DISC_SECTORS;
    cfg_data  = '0;
    disc_cur  = 0;
    region_base = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_on = 1'b1;

    configure(LBA_MAX, 1'b1);
    send_item(mk_item(CMD_LOOKUP, 0, 0, 0, 1'b0));
    send_item(mk_item(CMD_FILL, 0, 0, 0, 1'b0));
    send_item(mk_item(CMD_LOOKUP, 'hF, 0, 0, 1'b0));
    send_item(mk_item(CMD_FILL, 'hFFFF0, 0, 0, 1'b0));
    send_item(mk_item(CMD_LOOKUP, 'hFFFFE, 0, 0, 1'b0));
    // last sector equals the disc size, so it is out of range
    send_item(mk_item(CMD_LOOKUP, LBA_MAX, LBA_MAX, LBA_MAX, 1'b1));
    // two blocks folding onto the same directory entry
    send_item(mk_item(CMD_FILL, 'h400, 0, 0, 1'b0));
    send_item(mk_item(CMD_FILL, 'h10, 0, 0, 1'b0));
    send_item(mk_item(CMD_LOOKUP, 'h400, 0, 0, 1'b0));
    send_item(mk_item(CMD_READ_AHEAD, 'h100, 'h100, 'h1FF, 1'b1));
    send_item(mk_item(CMD_READ_AHEAD, 'h100, 'h100, 'h1FF, 1'b1));
    send_item(mk_item(CMD_READ_AHEAD, 'h500, 'h500, 'h5FF, 1'b0));
    send_item(mk_item(CMD_READ_AHEAD, 'h205, 'h208, 'h2FF, 1'b1));
    send_item(mk_item(CMD_READ_AHEAD, 'h300, 'h300, 'h31F, 1'b1));
    send_item(mk_item(CMD_READ_AHEAD, 'hFFFC0, 'hFFF00, LBA_MAX, 1'b1));
    // ring runs full and blocks get dropped
    send_item(mk_item(CMD_READ_AHEAD, 'h1000, 0, LBA_MAX, 1'b1));
    send_item(mk_item(CMD_READ_AHEAD, 0, 0, LBA_MAX, 1'b1));
    send_item(mk_item(CMD_POP, 0, 0, 0, 1'b0));
    send_item(mk_item(CMD_POP, LBA_MAX, LBA_MAX, LBA_MAX, 1'b1));
    send_item(mk_item(CMD_SPARE_LAST, LBA_MAX, LBA_MAX, LBA_MAX, 1'b1));
    wait_all_replies();

    configure('h400, 1'b0);
    send_item(mk_item(CMD_LOOKUP, 'h400, 0, 0, 1'b0));
    send_item(mk_item(CMD_FILL, 'h7FF, 0, 0, 1'b0));
    send_item(mk_item(CMD_POP, 0, 0, 0, 1'b0));
    send_item(mk_item(CMD_READ_AHEAD, 'h40, 0, 'h3FF, 1'b1));

    for (int p = 0; p < PHASES; p++) begin
      wait_all_replies();
      case (p)
        0: begin disc = LBA_MAX; enable = 1'b1; end
        2: begin disc = 0; enable = 1'b1; end
        3: begin disc = $urandom_range(1024, LBA_MAX); enable = 1'b0; end
        6: begin disc = LBA_MAX; enable = 1'b1; end
        default: begin disc = $urandom_range(1, LBA_MAX); enable = 1'b1; end
      endcase
      configure(disc, enable);
      region_base = $urandom_range(0, (disc > 1024) ? disc - 1024 : 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) idle_on = (p < PHASES - 2) && ($urandom_range(0, 2) != 0);
        send_item(random_item());
      end
    end

    // halt is sticky, so it is exercised last
    wait_all_replies();
    configure(LBA_MAX, 1'b1);
    send_item(mk_item(CMD_READ_AHEAD, 'h8000, 0, LBA_MAX, 1'b1));
    send_item(mk_item(CMD_FAIL, 0, 0, 0, 1'b0));
    send_item(mk_item(CMD_LOOKUP, 0, 0, 0, 1'b0));
    send_item(mk_item(CMD_FILL, 'h20, 0, 0, 1'b0));
    send_item(mk_item(CMD_READ_AHEAD, 'h100, 'h100, 'h1FF, 1'b1));
    send_item(mk_item(CMD_POP, 0, 0, 0, 1'b0));
    send_item(mk_item(CMD_FAIL, LBA_MAX, LBA_MAX, LBA_MAX, 1'b1));
    send_item(mk_item(CMD_SPARE_FIRST, 0, 0, 0, 1'b0));
    wait_all_replies();
    repeat (100) @(posedge clk);

    sb.flush_check();
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/sbcp_pkg.sv
hw/rtl/sbcp_ctrl.sv
hw/rtl/sbcp_dp.sv
hw/rtl/sector_block_cache_prefetch_top.sv
hw/rtl/sbcp_checker.sv
tb/testbench.sv
